### rtl/apsc_pkg.sv
// ----------------------------------------------------------------------------
// apsc_pkg: shared types and constants of the angle PID step controller
// Field widths, fixed-point layout, register indexes and the structs that
// pass an item, per-motor state and results between modules.
// ----------------------------------------------------------------------------
package apsc_pkg;

  // Encoder angle: 4096 counts per turn
  localparam int ANGLE_BITS = 12;
  localparam int ERR_W      = ANGLE_BITS + 1;   // wrapped error, [-half, half]
  localparam int DIFF_W     = ANGLE_BITS + 2;   // raw difference and derivative

  localparam int GAIN_W     = 24;               // Q8.16 signed gains
  localparam int FRAC_BITS  = 16;
  localparam int SUM_W      = 32;               // saturating error integral
  localparam int TIME_W     = 32;               // millisecond time stamps
  localparam int LIMIT_W    = 16;
  localparam int THRESH_W   = 12;
  localparam int PERIOD_W   = 16;

  localparam int STEP_W     = 17;               // clamped step output
  localparam int AERR_W     = 13;               // reported angle error

  localparam int PROD_P_W   = GAIN_W + ERR_W;
  localparam int PROD_I_W   = GAIN_W + SUM_W;
  localparam int PROD_D_W   = GAIN_W + DIFF_W;
  localparam int ACC_W      = PROD_I_W + 2;     // room for the sum of three products
  localparam int STEPS_W    = ACC_W - FRAC_BITS;

  // Stream and configuration port widths
  localparam int IN_TDATA_W  = 56;   // target, measured, now_ms
  localparam int OUT_TDATA_W = 32;   // drive_on, direction, step_output, angle_error
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 24;

  localparam int NUM_MOTORS_DEF = 2;

  // Reset values of the configuration registers
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST      = 24'sd65536;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST      = 24'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST      = 24'sd0;
  localparam logic [LIMIT_W-1:0]       STEP_LIMIT_RST  = 16'd200;
  localparam logic [THRESH_W-1:0]      THRESHOLD_RST   = 12'd23;
  localparam logic [PERIOD_W-1:0]      PERIOD_RST      = 16'd10;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_STEP_LIMIT      = 3'd3,
    REG_DRIVE_THRESH    = 3'd4,
    REG_UPDATE_PERIOD   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic [LIMIT_W-1:0]       step_limit;
    logic [THRESH_W-1:0]      drive_thresh;
    logic [PERIOD_W-1:0]      update_period_ms;
  } cfg_t;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] target_angle;
    logic [ANGLE_BITS-1:0] measured_angle;
    logic [TIME_W-1:0]     now_ms;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0]       last_update_time;
    logic signed [SUM_W-1:0] error_sum;
    logic signed [ERR_W-1:0] prior_error;
  } motor_state_t;

  typedef struct packed {
    logic                     updated;
    logic                     drive_on;
    logic                     direction;
    logic signed [STEP_W-1:0] step_output;
    logic signed [AERR_W-1:0] angle_error;
  } result_t;

endpackage

### rtl/apsc_core.sv
// ----------------------------------------------------------------------------
// apsc_core: one PID update of one motor
// Checks the update period, wraps the angle error, saturates the integral,
// forms the three gain products, truncates toward zero and clamps.
// ----------------------------------------------------------------------------
module apsc_core import apsc_pkg::*; (
  input  logic         motor_ok,
  input  item_t        item,
  input  motor_state_t cur_state,
  input  cfg_t         cfg,
  output result_t      res,
  output motor_state_t nxt_state
);

  localparam logic signed [DIFF_W-1:0] HALF_C = DIFF_W'(2 ** (ANGLE_BITS - 1));
  localparam logic signed [DIFF_W-1:0] FULL_C = DIFF_W'(2 ** ANGLE_BITS);
  localparam logic signed [ACC_W-1:0]  FRAC_MASK_C = ACC_W'(2 ** FRAC_BITS - 1);
  localparam logic signed [SUM_W:0]    SUM_MAX_C =
    (SUM_W+1)'((64'sd1 <<< (SUM_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W:0]    SUM_MIN_C =
    -((SUM_W+1)'(64'sd1 <<< (SUM_W - 1)));

  logic [TIME_W-1:0]        elapsed;
  logic                     due;
  logic signed [DIFF_W-1:0] e_raw;
  logic signed [DIFF_W-1:0] e_wrap;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_P_W-1:0] prod_p;
  logic signed [PROD_I_W-1:0] prod_i;
  logic signed [PROD_D_W-1:0] prod_d;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_adj;
  logic signed [STEPS_W-1:0] steps;
  logic signed [STEPS_W-1:0] lim_pos;
  logic signed [STEPS_W-1:0] lim_neg;
  logic signed [STEPS_W-1:0] steps_clamped;
  logic [ERR_W-1:0]         err_mag;

  assign elapsed = item.now_ms - cur_state.last_update_time;
  assign due     = motor_ok && (elapsed >= TIME_W'(cfg.update_period_ms));

  // Wrap into [-half, half]; exactly +/- half stays as is
  assign e_raw = $signed({2'b00, item.target_angle}) - $signed({2'b00, item.measured_angle});

  always_comb begin
    e_wrap = e_raw;
    if (e_raw > HALF_C) begin
      e_wrap = e_raw - FULL_C;
    end else if (e_raw < -HALF_C) begin
      e_wrap = e_raw + FULL_C;
    end
  end

  assign err = e_wrap[ERR_W-1:0];

  // Saturate the integral to the signed 32-bit range
  assign sum_ext = (SUM_W+1)'(cur_state.error_sum) + (SUM_W+1)'(err);

  always_comb begin
    if (sum_ext > SUM_MAX_C) begin
      sum_sat = SUM_MAX_C[SUM_W-1:0];
    end else if (sum_ext < SUM_MIN_C) begin
      sum_sat = SUM_MIN_C[SUM_W-1:0];
    end else begin
      sum_sat = sum_ext[SUM_W-1:0];
    end
  end

  assign diff = DIFF_W'(err) - DIFF_W'(cur_state.prior_error);

  assign prod_p = cfg.gain_p * err;
  assign prod_i = cfg.gain_i * sum_sat;
  assign prod_d = cfg.gain_d * diff;

  assign acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

  // Truncate toward zero: bias negative values before the arithmetic shift
  assign acc_adj = acc + (acc[ACC_W-1] ? FRAC_MASK_C : '0);
  assign steps   = acc_adj[ACC_W-1:FRAC_BITS];

  assign lim_pos = $signed(STEPS_W'(cfg.step_limit));
  assign lim_neg = -lim_pos;

  always_comb begin
    if (steps > lim_pos) begin
      steps_clamped = lim_pos;
    end else if (steps < lim_neg) begin
      steps_clamped = lim_neg;
    end else begin
      steps_clamped = steps;
    end
  end

  assign err_mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);

  always_comb begin
    res       = '0;
    nxt_state = cur_state;
    if (due) begin
      res.updated     = 1'b1;
      res.drive_on    = err_mag > ERR_W'(cfg.drive_thresh);
      res.direction   = steps_clamped > 0;
      res.step_output = STEP_W'(steps_clamped);
      res.angle_error = AERR_W'(err);
      nxt_state.last_update_time = item.now_ms;
      nxt_state.error_sum        = sum_sat;
      nxt_state.prior_error      = err;
    end
  end

endmodule

### rtl/angle_pid_step_controller.sv
// ----------------------------------------------------------------------------
// angle_pid_step_controller: per-motor PID position controller with angle wrap
// Stream in encoder samples, stream out one step command per sample.
// ----------------------------------------------------------------------------
// Each input item (motor number, target angle, measured angle, millisecond
// time) gives exactly one result item: the item is held in the input register,
// and its result is loaded into the result register once that register is free.
// The block takes one item every cycle unless the output stalls: an item sits
// in the input register, the whole update (period check, error wrap, integral
// saturation, three Q8.16 products, truncation and clamp) is one pass of
// combinational logic, and the per-motor state is written back at the same
// edge that loads the result register, so back-to-back items for the same
// motor see each other's update. The path through the integral multiply sets
// the clock limit. A motor whose update period has not elapsed, or a motor
// number not below NUM_MOTORS, gives a result with tuser low and tdata zero
// and leaves the state alone. Write configuration only while no item is in
// flight.
// ----------------------------------------------------------------------------
module angle_pid_step_controller import apsc_pkg::*; #(
  parameter int NUM_MOTORS = NUM_MOTORS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input stream
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // target_angle[11:0], measured_angle[23:12],
                                             // now_ms[55:24]
  input  logic                   in_tuser,   // motor_select[0]
  // result stream
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // drive_on[0], direction[1], step_output[18:2],
                                             // angle_error[31:19]
  output logic                   out_tuser,  // updated[0]
  // configuration writes
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int MOTOR_IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

  cfg_t         cfg_r;
  logic         in_valid_r;
  logic         in_valid_nxt;
  item_t        in_item_r;
  logic         in_motor_r;
  logic         out_valid_r;
  logic         out_valid_nxt;
  result_t      out_res_r;
  motor_state_t state_r [NUM_MOTORS];

  logic                   advance;
  logic                   in_fire;
  logic                   motor_ok;
  logic [MOTOR_IDX_W-1:0] motor_idx;
  motor_state_t           cur_state;
  motor_state_t           nxt_state;
  result_t                res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p           <= GAIN_P_RST;
      cfg_r.gain_i           <= GAIN_I_RST;
      cfg_r.gain_d           <= GAIN_D_RST;
      cfg_r.step_limit       <= STEP_LIMIT_RST;
      cfg_r.drive_thresh     <= THRESHOLD_RST;
      cfg_r.update_period_ms <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_GAIN_P:          cfg_r.gain_p           <= $signed(cfg_wdata[GAIN_W-1:0]);
        REG_GAIN_I:          cfg_r.gain_i           <= $signed(cfg_wdata[GAIN_W-1:0]);
        REG_GAIN_D:          cfg_r.gain_d           <= $signed(cfg_wdata[GAIN_W-1:0]);
        REG_STEP_LIMIT:      cfg_r.step_limit       <= cfg_wdata[LIMIT_W-1:0];
        REG_DRIVE_THRESH:    cfg_r.drive_thresh     <= cfg_wdata[THRESH_W-1:0];
        REG_UPDATE_PERIOD:   cfg_r.update_period_ms <= cfg_wdata[PERIOD_W-1:0];
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  // Handshake: the result register frees up when empty or being taken,
  // and the input register advances whenever the result register does.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt  = in_valid_r;
    out_valid_nxt = out_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
    if (advance) begin
      out_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register: capture the item payload on acceptance
  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.target_angle   <= in_tdata[ANGLE_BITS-1:0];
      in_item_r.measured_angle <= in_tdata[2*ANGLE_BITS-1:ANGLE_BITS];
      in_item_r.now_ms         <= in_tdata[2*ANGLE_BITS+TIME_W-1:2*ANGLE_BITS];
      in_motor_r               <= in_tuser;
    end
  end

  // Select the motor's state; an out-of-range motor reads as all zero
  assign motor_idx = MOTOR_IDX_W'(in_motor_r);
  assign motor_ok  = (int'(in_motor_r) < NUM_MOTORS);
  assign cur_state = motor_ok ? state_r[motor_idx] : '0;

  apsc_core u_core (
    .motor_ok  (motor_ok),
    .item      (in_item_r),
    .cur_state (cur_state),
    .cfg       (cfg_r),
    .res       (res),
    .nxt_state (nxt_state)
  );

  // Per-motor state: write back only when the item leaves with an update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_MOTORS; k++) begin
        state_r[k] <= '0;
      end
    end else if (advance && in_valid_r && res.updated) begin
      state_r[motor_idx] <= nxt_state;
    end
  end

  // Result register: load the new result, hold it while stalled
  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.updated;
  assign out_tdata  = {out_res_r.angle_error, out_res_r.step_output,
                       out_res_r.direction, out_res_r.drive_on};

endmodule

### rtl/apsc_checker.sv
// ----------------------------------------------------------------------------
// apsc_checker: port-level assertions for the angle PID step controller
// Watches the stream ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module apsc_checker import apsc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A new result appears only after an accepted item has passed the input register
  a_out_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input item");

  // A result without an update carries all-zero data
  a_no_update_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("non-updated result has nonzero data");

  // Direction means a strictly positive step output; zero error never drives
  a_dir_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[18] && out_tdata[18:2] != '0)
    else $error("direction set without positive step output");

  a_zero_err_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[31:19] == '0 |-> !out_tdata[0])
    else $error("drive enabled with zero angle error");

endmodule

bind angle_pid_step_controller apsc_checker u_apsc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
